FILE: rtl/lapf_pkg.sv
// shared types and constants for the 3x3 laplacian rgb edge filter
package lapf_pkg;

   localparam int MAX_WIDTH    = 2048;
   localparam int COL_WIDTH    = $clog2(MAX_WIDTH);
   localparam int ROW_WIDTH    = 12;
   localparam int SIZE_WIDTH   = 12;
   localparam int CSR_IDX_WIDTH = 2;

   localparam logic [SIZE_WIDTH-1:0] WIDTH_RESET  = SIZE_WIDTH'(640);
   localparam logic [SIZE_WIDTH-1:0] HEIGHT_RESET = SIZE_WIDTH'(480);
   localparam logic [SIZE_WIDTH-1:0] SIZE_MIN     = SIZE_WIDTH'(3);
   localparam logic [SIZE_WIDTH-1:0] WIDTH_MAX    = SIZE_WIDTH'(MAX_WIDTH);

   typedef logic [CSR_IDX_WIDTH-1:0] csr_index_type;
   localparam csr_index_type CSR_IMAGE_WIDTH  = csr_index_type'(0);
   localparam csr_index_type CSR_IMAGE_HEIGHT = csr_index_type'(1);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   localparam int PIXEL_WIDTH = $bits(pixel_type);

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0] out_row;
      logic [COL_WIDTH-1:0] out_col;
      logic [7:0]           red_out;
      logic [7:0]           green_out;
      logic [7:0]           blue_out;
      logic                 frame_done;
   } rsp_payload_type;

endpackage

FILE: rtl/lapf_ram.sv
// generic single-write, single-read ram with registered read data
module lapf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lapf_kernel.sv
// 3x3 laplacian kernel: 8 * center minus the eight neighbours, per channel, mod 256
module lapf_kernel (
   input  lapf_pkg::pixel_type [8:0] win,
   output lapf_pkg::pixel_type       result
);
   import lapf_pkg::*;

   logic [7:0] sum_r;
   logic [7:0] sum_g;
   logic [7:0] sum_b;

   // neighbour sums wrap at 8 bits, which is all the low byte needs
   always_comb begin
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      for (int k = 0; k < 9; k++) begin
         if (k != 4) begin
            sum_r = sum_r + win[k].red;
            sum_g = sum_g + win[k].green;
            sum_b = sum_b + win[k].blue;
         end
      end
      result.red   = {win[4].red[4:0], 3'b000}   - sum_r;
      result.green = {win[4].green[4:0], 3'b000} - sum_g;
      result.blue  = {win[4].blue[4:0], 3'b000}  - sum_b;
   end

endmodule

FILE: rtl/laplacian_3x3_rgb_filter_core.sv
// top level of the 3x3 laplacian rgb edge filter
//
//  channel | direction | handshake           | beat
//  --------+-----------+---------------------+------------------------------------
//  req     | in        | req_valid/req_stall | one rgb pixel, raster order
//  rsp     | out       | rsp_valid/rsp_stall | one filtered interior pixel
//  csr     | in        | csr_valid/csr_ready | register index and 12-bit value
//
// one pixel per clock while req_stall is low; a result passes the ram stage and the result queue
// the rate is set by the single read and single write port of the line ram,
// which sees one read-modify-write per pixel
// reset is synchronous; the line ram is not cleared, the window and counters are
// req_stall rises whenever both slots of the two-entry result queue will be taken
module laplacian_3x3_rgb_filter_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lapf_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lapf_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  lapf_pkg::csr_index_type   csr_index,
   input  logic [lapf_pkg::SIZE_WIDTH-1:0] csr_wdata
);
   import lapf_pkg::*;

   localparam int LINE_WIDTH = 2 * PIXEL_WIDTH;

   // configuration
   logic [SIZE_WIDTH-1:0] width_cfg_ff;
   logic [SIZE_WIDTH-1:0] height_cfg_ff;
   logic [SIZE_WIDTH-1:0] eff_width;
   logic [SIZE_WIDTH-1:0] eff_height;

   // raster position of the next pixel
   logic [ROW_WIDTH-1:0] row_ff;
   logic [ROW_WIDTH-1:0] row_in;
   logic [COL_WIDTH-1:0] col_ff;
   logic [COL_WIDTH-1:0] col_in;

   // accept stage
   logic                 accept;
   logic [ROW_WIDTH-1:0] cur_row;
   logic [COL_WIDTH-1:0] cur_col;
   logic [SIZE_WIDTH-1:0] col_next;
   logic [ROW_WIDTH:0]   row_next;
   logic                 cur_hit;
   logic                 cur_done;

   // ram stage
   logic                 s1_valid_ff;
   logic [COL_WIDTH-1:0] s1_addr_ff;
   pixel_type            s1_pix_ff;
   logic                 s1_hit_ff;
   logic                 s1_done_ff;
   logic [ROW_WIDTH-1:0] s1_row_ff;
   logic [COL_WIDTH-1:0] s1_col_ff;

   logic [LINE_WIDTH-1:0] ram_rd_data;
   logic [LINE_WIDTH-1:0] ram_wr_data;
   logic [LINE_WIDTH-1:0] line_data;
   logic                  fwd_hit_ff;
   logic [LINE_WIDTH-1:0] fwd_data_ff;
   pixel_type             top_pix;
   pixel_type             mid_pix;

   // window of the two previous columns, rows r-2..r
   pixel_type             wc_ff [6];
   pixel_type [8:0]       win;
   pixel_type             filt;

   // result queue, slot 0 is the head
   rsp_payload_type       q_ff [2];
   rsp_payload_type       q_in [2];
   rsp_payload_type       push_data;
   logic [1:0]            q_count_ff;
   logic [1:0]            q_count_in;
   logic [1:0]            q_after_pop;
   logic                  push;
   logic                  pop;

   // ---------------- configuration registers ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= WIDTH_RESET;
         height_cfg_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_cfg_ff  <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp the frame size: at least SIZE_MIN each way, width at most what the line ram holds
   always_comb begin
      if (width_cfg_ff < SIZE_MIN) begin
         eff_width = SIZE_MIN;
      end else if (width_cfg_ff > WIDTH_MAX) begin
         eff_width = WIDTH_MAX;
      end else begin
         eff_width = width_cfg_ff;
      end
      eff_height = (height_cfg_ff < SIZE_MIN) ? SIZE_MIN : height_cfg_ff;
   end

   // ---------------- accept stage: position and ram read ----------------
   assign accept = req_valid && !req_stall;

   always_comb begin
      cur_row  = req_data.frame_start ? '0 : row_ff;
      cur_col  = req_data.frame_start ? '0 : col_ff;
      col_next = {1'b0, cur_col} + SIZE_WIDTH'(1);
      row_next = {1'b0, cur_row} + (ROW_WIDTH+1)'(1);

      // interior pixel centered one row up and one column left
      cur_hit  = (cur_row >= ROW_WIDTH'(2)) && (cur_col >= COL_WIDTH'(2)) &&
                 (cur_row < eff_height) && ({1'b0, cur_col} < eff_width);
      cur_done = (cur_row == eff_height - SIZE_WIDTH'(1)) &&
                 ({1'b0, cur_col} == eff_width - SIZE_WIDTH'(1));

      // counters wrap as soon as they reach or pass the last column or row
      if (col_next >= eff_width) begin
         col_in = '0;
         row_in = (row_next >= {1'b0, eff_height}) ? '0 : row_next[ROW_WIDTH-1:0];
      end else begin
         col_in = col_next[COL_WIDTH-1:0];
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_hit_ff  <= 1'b0;
      end else begin
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
         s1_valid_ff <= accept;
         // the ram returns old data when the previous pixel writes the same entry
         fwd_hit_ff  <= accept && s1_valid_ff && (s1_addr_ff == cur_col);
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= ram_wr_data;
      if (accept) begin
         s1_addr_ff <= cur_col;
         s1_pix_ff  <= pixel_type'({req_data.red_in, req_data.green_in, req_data.blue_in});
         s1_hit_ff  <= cur_hit;
         s1_done_ff <= cur_done;
         s1_row_ff  <= cur_row - ROW_WIDTH'(1);
         s1_col_ff  <= cur_col - COL_WIDTH'(1);
      end
   end

   // ---------------- line ram: upper row in the high half, middle row low ----------------
   lapf_ram #(
      .WIDTH (LINE_WIDTH),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (ram_rd_data)
   );

   assign line_data   = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign top_pix     = pixel_type'(line_data[LINE_WIDTH-1:PIXEL_WIDTH]);
   assign mid_pix     = pixel_type'(line_data[PIXEL_WIDTH-1:0]);
   // rows shift down by one in the ram entry of this column
   assign ram_wr_data = {mid_pix, s1_pix_ff};

   // ---------------- window and kernel ----------------
   always_comb begin
      win[0] = wc_ff[0];
      win[1] = wc_ff[3];
      win[2] = top_pix;
      win[3] = wc_ff[1];
      win[4] = wc_ff[4];
      win[5] = mid_pix;
      win[6] = wc_ff[2];
      win[7] = wc_ff[5];
      win[8] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            wc_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         wc_ff[0] <= wc_ff[3];
         wc_ff[1] <= wc_ff[4];
         wc_ff[2] <= wc_ff[5];
         wc_ff[3] <= top_pix;
         wc_ff[4] <= mid_pix;
         wc_ff[5] <= s1_pix_ff;
      end
   end

   lapf_kernel u_kernel (
      .win    (win),
      .result (filt)
   );

   // ---------------- result queue ----------------
   assign push = s1_valid_ff && s1_hit_ff;
   assign pop  = rsp_valid && !rsp_stall;

   always_comb begin
      push_data.out_row    = s1_row_ff;
      push_data.out_col    = s1_col_ff;
      push_data.red_out    = filt.red;
      push_data.green_out  = filt.green;
      push_data.blue_out   = filt.blue;
      push_data.frame_done = s1_done_ff;

      q_after_pop = q_count_ff - {1'b0, pop};
      q_in[0]     = pop ? q_ff[1] : q_ff[0];
      q_in[1]     = q_ff[1];
      if (push) begin
         if (q_after_pop == 2'd0) begin
            q_in[0] = push_data;
         end else begin
            q_in[1] = push_data;
         end
      end
      q_count_in = q_after_pop + {1'b0, push};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_count_ff <= '0;
      end else begin
         q_count_ff <= q_count_in;
      end
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   // a pixel taken now is pushed into the queue in the next cycle, so keep one slot free
   assign req_stall = (q_count_in == 2'd2);
   assign rsp_valid = (q_count_ff != 2'd0);
   assign rsp_data  = q_ff[0];

endmodule

FILE: tb/tb.sv
// self-checking testbench for the 3x3 laplacian rgb edge filter core
`timescale 1ns / 1ps

module tb;
   import lapf_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int IDLE_PERCENT   = 38;
   localparam int RANDOM_ITEMS   = 1150;
   localparam int WIDE_ITEMS     = 64;

   // indexes past the register list, writes there must be ignored
   localparam csr_index_type CSR_SPARE_LO = csr_index_type'(2);
   localparam csr_index_type CSR_SPARE_HI = csr_index_type'(3);

   typedef enum logic [1:0] {STEP_PIXEL, STEP_CSR} step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      req_payload_type       pixel;
      csr_index_type         index;
      logic [SIZE_WIDTH-1:0] value;
      logic                  typed;
      rsp_payload_type       golden;
   } plan_step_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_payload_type       req_data;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [SIZE_WIDTH-1:0] csr_wdata;

   // predictor state: line stores, window, position and size registers
   pixel_type             line_upper [MAX_WIDTH];
   pixel_type             line_middle [MAX_WIDTH];
   bit                    upper_known [MAX_WIDTH];
   bit                    middle_known [MAX_WIDTH];
   pixel_type             win_cols [6];
   bit                    win_known [6];
   int unsigned           row_pos;
   int unsigned           col_pos;
   logic [SIZE_WIDTH-1:0] width_reg;
   logic [SIZE_WIDTH-1:0] height_reg;

   rsp_payload_type       pending_filtered [$];
   plan_step_type         directed_plan [$];
   rsp_payload_type       oldest;
   int                    errors = 0;
   int                    quiet_cycles = 0;
   bit                    calm = 1'b0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   laplacian_3x3_rgb_filter_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   function automatic int unsigned active_width();
      if (width_reg < SIZE_MIN) return 32'(SIZE_MIN);
      if (width_reg > WIDTH_MAX) return 32'(WIDTH_MAX);
      return 32'(width_reg);
   endfunction

   function automatic int unsigned active_height();
      return (height_reg < SIZE_MIN) ? 32'(SIZE_MIN) : 32'(height_reg);
   endfunction

   // 8 * center minus the eight neighbours, wrapped to a byte
   function automatic logic [7:0] lap_byte(input logic [71:0] taps);
      logic [7:0] acc;
      acc = taps[32 +: 8] << 3;
      for (int k = 0; k < 9; k++)
         if (k != 4) acc = acc - taps[k*8 +: 8];
      return acc;
   endfunction

   // true when this pixel would emit a result built from a never-written store entry
   function automatic bit reads_unknown(input req_payload_type px);
      int unsigned r;
      int unsigned c;
      bit          ok;
      r = px.frame_start ? 0 : row_pos;
      c = px.frame_start ? 0 : col_pos;
      if (!(r >= 2 && c >= 2 && r < active_height() && c < active_width())) return 1'b0;
      ok = upper_known[c] && middle_known[c];
      for (int k = 0; k < 6; k++) ok = ok && win_known[k];
      return !ok;
   endfunction

   task automatic filter_pixel(input req_payload_type px, output bit hit,
                               output rsp_payload_type res);
      pixel_type   pix;
      pixel_type   top;
      pixel_type   mid;
      bit          top_ok;
      bit          mid_ok;
      pixel_type   nb [9];
      logic [71:0] taps_r;
      logic [71:0] taps_g;
      logic [71:0] taps_b;
      int unsigned r;
      int unsigned c;
      int unsigned w;
      int unsigned h;
      w   = active_width();
      h   = active_height();
      pix = {px.red_in, px.green_in, px.blue_in};
      if (px.frame_start) begin
         row_pos = 0;
         col_pos = 0;
      end
      r      = row_pos;
      c      = col_pos;
      top    = line_upper[c];
      mid    = line_middle[c];
      top_ok = upper_known[c];
      mid_ok = middle_known[c];
      line_upper[c]   = mid;
      upper_known[c]  = mid_ok;
      line_middle[c]  = pix;
      middle_known[c] = 1'b1;
      // window rows r-2, r-1, r across columns c-2, c-1, c
      nb[0] = win_cols[0]; nb[1] = win_cols[3]; nb[2] = top;
      nb[3] = win_cols[1]; nb[4] = win_cols[4]; nb[5] = mid;
      nb[6] = win_cols[2]; nb[7] = win_cols[5]; nb[8] = pix;
      for (int k = 0; k < 9; k++) begin
         taps_r[k*8 +: 8] = nb[k].red;
         taps_g[k*8 +: 8] = nb[k].green;
         taps_b[k*8 +: 8] = nb[k].blue;
      end
      hit = (r >= 2 && c >= 2 && r < h && c < w);
      res = '0;
      if (hit) begin
         res.out_row    = ROW_WIDTH'(r - 1);
         res.out_col    = COL_WIDTH'(c - 1);
         res.red_out    = lap_byte(taps_r);
         res.green_out  = lap_byte(taps_g);
         res.blue_out   = lap_byte(taps_b);
         res.frame_done = (r == h - 1 && c == w - 1);
      end
      for (int k = 0; k < 3; k++) begin
         win_cols[k]  = win_cols[k+3];
         win_known[k] = win_known[k+3];
      end
      win_cols[3] = top;  win_known[3] = top_ok;
      win_cols[4] = mid;  win_known[4] = mid_ok;
      win_cols[5] = pix;  win_known[5] = 1'b1;
      // counters wrap once they reach or pass the last column or row
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : ((r + 1) & 32'hFFF);
      end else begin
         col_pos = c + 1;
      end
   endtask

   function automatic logic [7:0] random_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic req_payload_type random_pixel();
      req_payload_type px;
      px.red_in      = random_byte();
      px.green_in    = random_byte();
      px.blue_in     = random_byte();
      px.frame_start = 1'b0;
      return px;
   endfunction

   task automatic send_pixel(input req_payload_type px, input bit typed,
                             input rsp_payload_type golden);
      bit              hit;
      rsp_payload_type res;
      // restart the frame rather than feed the filter from unwritten line entries
      if (reads_unknown(px)) px.frame_start = 1'b1;
      filter_pixel(px, hit, res);
      if (typed) pending_filtered.push_back(golden);
      else if (hit) pending_filtered.push_back(res);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // register writes only once the pipeline has emptied
   task automatic write_csr(input csr_index_type idx, input logic [SIZE_WIDTH-1:0] val);
      req_valid <= 1'b0;
      while (pending_filtered.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  width_reg  = val;
         CSR_IMAGE_HEIGHT: height_reg = val;
         default: ;
      endcase
   endtask

   task automatic add_pixel_step(input req_payload_type px, input bit typed,
                                 input rsp_payload_type golden);
      plan_step_type s;
      s        = '0;
      s.kind   = STEP_PIXEL;
      s.pixel  = px;
      s.typed  = typed;
      s.golden = golden;
      directed_plan.push_back(s);
   endtask

   task automatic add_csr_step(input csr_index_type idx, input logic [SIZE_WIDTH-1:0] val);
      plan_step_type s;
      s       = '0;
      s.kind  = STEP_CSR;
      s.index = idx;
      s.value = val;
      directed_plan.push_back(s);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // result side: random stall, compare each beat with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_filtered.size() == 0) begin
               $display("%0t: result with nothing expected, actual row %0d col %0d",
                        $time, rsp_data.out_row, rsp_data.out_col);
               errors++;
            end else begin
               oldest = pending_filtered.pop_front();
               check_field("out_row", oldest.out_row, rsp_data.out_row);
               check_field("out_col", oldest.out_col, rsp_data.out_col);
               check_field("red_out", oldest.red_out, rsp_data.red_out);
               check_field("green_out", oldest.green_out, rsp_data.green_out);
               check_field("blue_out", oldest.blue_out, rsp_data.blue_out);
               check_field("frame_done", oldest.frame_done, rsp_data.frame_done);
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("** laplacian_3x3_rgb_filter_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int              random_sent;
      int              phase;
      int              frames;
      int              span;
      bit              fresh;
      req_payload_type px;
      rsp_payload_type golden;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wdata = '0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      row_pos    = 0;
      col_pos    = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         line_upper[i]   = '0;
         line_middle[i]  = '0;
         upper_known[i]  = 1'b0;
         middle_known[i] = 1'b0;
      end
      for (int k = 0; k < 6; k++) begin
         win_cols[k]  = '0;
         win_known[k] = 1'b1;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset size 640x480: a few pixels on row 0 give nothing
      golden = '0;
      px = {8'd12, 8'd34, 8'd56, 1'b1};
      add_pixel_step(px, 1'b0, golden);
      px = {8'hFF, 8'h00, 8'hFF, 1'b0};
      add_pixel_step(px, 1'b0, golden);
      px = {8'h00, 8'hFF, 8'h00, 1'b0};
      add_pixel_step(px, 1'b0, golden);
      // sizes below the floor act as 3x3; spare indexes are ignored
      add_csr_step(CSR_IMAGE_WIDTH, 12'd1);
      add_csr_step(CSR_IMAGE_HEIGHT, 12'd0);
      add_csr_step(CSR_SPARE_LO, 12'hFFF);
      add_csr_step(CSR_SPARE_HI, 12'hABC);
      // bright center on black, frame start lands mid-row
      golden.out_row    = ROW_WIDTH'(1);
      golden.out_col    = COL_WIDTH'(1);
      golden.red_out    = 8'hF8;
      golden.green_out  = 8'hF8;
      golden.blue_out   = 8'hF8;
      golden.frame_done = 1'b1;
      for (int k = 0; k < 9; k++) begin
         px = (k == 4) ? {24'hFFFFFF, 1'b0} : {24'h000000, 1'b0};
         px.frame_start = (k == 0);
         add_pixel_step(px, k == 8, golden);
      end
      // black center on white wraps the other way
      golden.red_out   = 8'h08;
      golden.green_out = 8'h08;
      golden.blue_out  = 8'h08;
      for (int k = 0; k < 9; k++) begin
         px = (k == 4) ? {24'h000000, 1'b0} : {24'hFFFFFF, 1'b0};
         px.frame_start = (k == 0);
         add_pixel_step(px, k == 8, golden);
      end

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == STEP_CSR)
            write_csr(directed_plan[i].index, directed_plan[i].value);
         else
            send_pixel(directed_plan[i].pixel, directed_plan[i].typed,
                       directed_plan[i].golden);
      end

      // random phases of small frames, sizes changed between phases,
      // sometimes in the middle of a frame
      random_sent = 0;
      phase       = 0;
      golden      = '0;
      while (random_sent < RANDOM_ITEMS) begin
         calm = (phase % 5 == 3);
         if ($urandom_range(3) != 1)
            write_csr(CSR_IMAGE_WIDTH, ($urandom_range(7) == 0) ?
                      12'($urandom_range(2)) : 12'($urandom_range(3, 14)));
         if ($urandom_range(3) != 0)
            write_csr(CSR_IMAGE_HEIGHT, ($urandom_range(7) == 0) ?
                      12'($urandom_range(2)) : 12'($urandom_range(3, 9)));
         if ($urandom_range(5) == 0)
            write_csr($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI, 12'($urandom));
         fresh  = ($urandom_range(3) != 0);
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            span = active_width() * active_height();
            if ($urandom_range(7) == 0) span = $urandom_range(1, span);
            for (int k = 0; k < span; k++) begin
               px = random_pixel();
               px.frame_start = (k == 0 && (fresh || f > 0)) || ($urandom_range(79) == 0);
               send_pixel(px, 1'b0, golden);
               random_sent++;
            end
         end
         phase++;
      end
      calm = 1'b0;

      // widest row and shallowest frame: the start of the first row gives nothing
      write_csr(CSR_IMAGE_WIDTH, 12'hFFF);
      write_csr(CSR_IMAGE_HEIGHT, 12'd0);
      for (int k = 0; k < WIDE_ITEMS; k++) begin
         px = random_pixel();
         px.frame_start = (k == 0);
         send_pixel(px, 1'b0, golden);
      end

      // tallest frame, then the height drops below the current row
      write_csr(CSR_IMAGE_WIDTH, 12'd2);
      write_csr(CSR_IMAGE_HEIGHT, 12'hFFF);
      for (int k = 0; k < 3 * 40; k++) begin
         px = random_pixel();
         px.frame_start = (k == 0);
         send_pixel(px, 1'b0, golden);
      end
      write_csr(CSR_IMAGE_HEIGHT, 12'd7);
      for (int k = 0; k < 3 * 12; k++) begin
         px = random_pixel();
         send_pixel(px, 1'b0, golden);
      end

      req_valid <= 1'b0;
      while (pending_filtered.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES + 2) @(posedge clock);
      if (errors == 0)
         $display("** laplacian_3x3_rgb_filter_core: PASSED **");
      else
         $display("** laplacian_3x3_rgb_filter_core: FAILED **");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/lapf_pkg.sv
rtl/lapf_ram.sv
rtl/lapf_kernel.sv
rtl/laplacian_3x3_rgb_filter_core.sv
tb/tb.sv
